### rtl/core/rbri_pkg.sv
// ----------------------------------------------------------------------------
// Recording block ring indexer package
// Widths, codes, reset values and shared types for the ring indexer.
// ----------------------------------------------------------------------------
package rbri_pkg;

    localparam int TS_W      = 47;
    localparam int SIZE_W    = 25;
    localparam int FRAME_W   = 24;
    localparam int OFS_W     = 34;
    localparam int ROWF_W    = 10;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int REPAIR_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_ROWS_DEF   = 1024;
    localparam int MARK_BYTES_DEF = 4;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 25'd1048576;
    localparam logic [SIZE_W-1:0] MAX_FRAME_RST  = 25'd104857;

    // Commands
    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Result status
    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ROW     = 2'd3;

    // Repair codes
    localparam logic [REPAIR_W-1:0] REP_NONE  = 2'd0;
    localparam logic [REPAIR_W-1:0] REP_LAST  = 2'd1;
    localparam logic [REPAIR_W-1:0] REP_FIRST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] block_size;
        logic [SIZE_W-1:0] max_frame_size;
        logic              keyframe_mode;
        logic              start_load;
        logic [ROWF_W-1:0] start_row;
    } cfg_t;

endpackage

### rtl/core/rbri_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/rbri_cfg.sv
// ----------------------------------------------------------------------------
// Ring indexer configuration registers
// Decodes the write port and holds block size, frame limit and keyframe mode.
// ----------------------------------------------------------------------------
module rbri_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbri_pkg::SIZE_W-1:0]       cfg_data,
    output rbri_pkg::cfg_t                    cfg
);
    import rbri_pkg::*;

    logic [SIZE_W-1:0] block_size_reg;
    logic [SIZE_W-1:0] block_size_next;
    logic [SIZE_W-1:0] max_frame_reg;
    logic [SIZE_W-1:0] max_frame_next;
    logic              key_mode_reg;
    logic              key_mode_next;
    logic              start_load;

    always_comb
    begin
        block_size_next = block_size_reg;
        max_frame_next  = max_frame_reg;
        key_mode_next   = key_mode_reg;
        start_load      = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_SIZE: block_size_next = cfg_data;
                CFG_MAX_FRAME:  max_frame_next  = cfg_data;
                CFG_KEY_MODE:   key_mode_next   = cfg_data[0];
                CFG_START_ROW:  start_load      = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RST;
            max_frame_reg  <= MAX_FRAME_RST;
            key_mode_reg   <= 1'b0;
        end
        else
        begin
            block_size_reg <= block_size_next;
            max_frame_reg  <= max_frame_next;
            key_mode_reg   <= key_mode_next;
        end
    end

    // The start row loads the current row directly in the same cycle.
    always_comb
    begin
        cfg.block_size     = block_size_reg;
        cfg.max_frame_size = max_frame_reg;
        cfg.keyframe_mode  = key_mode_reg;
        cfg.start_load     = start_load;
        cfg.start_row      = cfg_data[ROWF_W-1:0];
    end

endmodule

### rtl/core/rbri_seq.sv
// ----------------------------------------------------------------------------
// Ring indexer sequencer
// Places frames, closes blocks by read-modify-write of the timestamp table,
// serves row reads and runs the table clearing pass after reset.
// ----------------------------------------------------------------------------
module rbri_seq #(
    parameter int NUM_ROWS   = rbri_pkg::NUM_ROWS_DEF,
    parameter int MARK_BYTES = rbri_pkg::MARK_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rbri_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rbri_pkg::CMD_W-1:0]           cmd,
    input  logic [rbri_pkg::FRAME_W-1:0]         frame_size,
    input  logic [rbri_pkg::TS_W-1:0]            timestamp_ms,
    input  logic                                 is_keyframe,
    input  logic                                 lead_stream,
    input  logic [rbri_pkg::ROWF_W-1:0]          row_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rbri_pkg::STATUS_W-1:0]        status,
    output logic [rbri_pkg::OFS_W-1:0]           write_offset,
    output logic                                 block_closed,
    output logic [rbri_pkg::ROWF_W-1:0]          closed_row,
    output logic [rbri_pkg::TS_W-1:0]            closed_first_ts,
    output logic [rbri_pkg::TS_W-1:0]            closed_last_ts,
    output logic [rbri_pkg::REPAIR_W-1:0]        repair_code,
    output logic [rbri_pkg::SIZE_W-1:0]          fill_bytes,
    output logic [rbri_pkg::ROWF_W-1:0]          next_row,
    output logic [rbri_pkg::TS_W-1:0]            row_first_ts,
    output logic [rbri_pkg::TS_W-1:0]            row_last_ts,
    output logic                                 mem_we,
    output logic [$clog2(NUM_ROWS)-1:0]          mem_waddr,
    output logic [2*rbri_pkg::TS_W-1:0]          mem_wdata,
    output logic [$clog2(NUM_ROWS)-1:0]          mem_raddr,
    input  logic [2*rbri_pkg::TS_W-1:0]          mem_rdata
);
    import rbri_pkg::*;

    localparam int ROW_W  = $clog2(NUM_ROWS);
    localparam int PROD_W = ROW_W + SIZE_W;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_ROWRD  = 7'b0001000,
        S_WRCUR  = 7'b0010000,
        S_WRNEXT = 7'b0100000,
        S_PLACE  = 7'b1000000
    } state_t;

    function automatic logic [ROW_W-1:0] row_ok(input logic [ROWF_W-1:0] r);
        if (32'(r) < 32'(NUM_ROWS))
        begin
            row_ok = ROW_W'(r);
        end
        else
        begin
            row_ok = '0;
        end
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]  last_row_reg, last_row_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;
    logic [TS_W-1:0]   pend_first_reg, pend_first_next;
    logic [TS_W-1:0]   pend_last_reg, pend_last_next;
    logic              out_valid_reg, out_valid_next;

    // Item and result payload
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [FRAME_W-1:0]  fsize_reg, fsize_next;
    logic [TS_W-1:0]     ts_reg, ts_next;
    logic                key_reg, key_next;
    logic                lead_reg, lead_next;
    logic [ROWF_W-1:0]   ridx_reg, ridx_next;
    logic [OFS_W-1:0]    row_base_reg, row_base_next;
    logic                cl_flag_reg, cl_flag_next;
    logic [ROWF_W-1:0]   cl_row_reg, cl_row_next;
    logic [TS_W-1:0]     cl_first_reg, cl_first_next;
    logic [TS_W-1:0]     cl_last_reg, cl_last_next;
    logic [REPAIR_W-1:0] cl_repair_reg, cl_repair_next;
    logic [SIZE_W-1:0]   cl_fill_reg, cl_fill_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [OFS_W-1:0]    o_offset_reg, o_offset_next;
    logic [ROWF_W-1:0]   o_next_row_reg, o_next_row_next;
    logic [TS_W-1:0]     o_row_first_reg, o_row_first_next;
    logic [TS_W-1:0]     o_row_last_reg, o_row_last_next;

    // Datapath terms
    logic                too_big;
    logic                need_close;
    logic [SIZE_W:0]     used;
    logic [SIZE_W-1:0]   close_fill;
    logic [SIZE_W:0]     fill_sum;
    logic [SIZE_W-1:0]   fill_sat;
    logic [OFS_W-1:0]    place_offset;
    logic [TS_W-1:0]     pf_new;
    logic [TS_W-1:0]     pl_new;
    logic [TS_W-1:0]     rd_first;
    logic [TS_W-1:0]     rd_last;
    logic [TS_W-1:0]     rep_first;
    logic [TS_W-1:0]     rep_last;
    logic [REPAIR_W-1:0] rep_code;
    logic [PROD_W-1:0]   prod;
    logic [ROW_W-1:0]    row_wrap;
    logic                out_free;
    logic                do_place;
    logic                do_emit;
    logic [STATUS_W-1:0] emit_status;

    assign rd_first = mem_rdata[2*TS_W-1:TS_W];
    assign rd_last  = mem_rdata[TS_W-1:0];

    always_comb
    begin
        too_big    = (26'(fsize_reg) + 26'(MARK_BYTES)) > 26'(cfg.max_frame_size);
        need_close = (27'(fill_reg) + 27'(fsize_reg) + 27'(MARK_BYTES))
                     > 27'(cfg.block_size);
        used       = 26'(fill_reg) + 26'(MARK_BYTES);
        close_fill = (26'(cfg.block_size) > used)
                     ? SIZE_W'(26'(cfg.block_size) - used) : '0;
        fill_sum   = 26'(fill_reg) + 26'(fsize_reg);
        fill_sat   = fill_sum[SIZE_W] ? '1 : fill_sum[SIZE_W-1:0];
        place_offset = row_base_reg + OFS_W'(fill_reg);

        pf_new = pend_first_reg;
        pl_new = pend_last_reg;
        if (lead_reg)
        begin
            if (key_reg)
            begin
                if (!cfg.keyframe_mode)
                begin
                    if (ts_reg > pend_first_reg)
                    begin
                        pf_new = ts_reg;
                    end
                end
                else if (pend_first_reg == '0 || ts_reg < pend_first_reg)
                begin
                    pf_new = ts_reg;
                end
            end
            if (ts_reg > pend_last_reg)
            begin
                pl_new = ts_reg;
            end
        end

        // Missing timestamps are copied from the previous row.
        rep_first = pend_first_reg;
        rep_last  = pend_last_reg;
        rep_code  = REP_NONE;
        if (pend_last_reg == '0)
        begin
            rep_last = rd_last;
            rep_code = REP_LAST;
        end
        if (pend_first_reg == '0)
        begin
            rep_first = rd_first;
            rep_code  = REP_FIRST;
        end

        row_wrap = (cur_row_reg == ROW_LAST) ? '0 : cur_row_reg + 1'b1;
        prod     = PROD_W'(cur_row_reg) * PROD_W'(cfg.block_size);
    end

    // Row base is registered from the current row and follows it in the next cycle.
    assign row_base_next = OFS_W'(prod);

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cur_row_next     = cur_row_reg;
        last_row_next    = last_row_reg;
        fill_next        = fill_reg;
        pend_first_next  = pend_first_reg;
        pend_last_next   = pend_last_reg;
        cmd_next         = cmd_reg;
        fsize_next       = fsize_reg;
        ts_next          = ts_reg;
        key_next         = key_reg;
        lead_next        = lead_reg;
        ridx_next        = ridx_reg;
        cl_flag_next     = cl_flag_reg;
        cl_row_next      = cl_row_reg;
        cl_first_next    = cl_first_reg;
        cl_last_next     = cl_last_reg;
        cl_repair_next   = cl_repair_reg;
        cl_fill_next     = cl_fill_reg;
        in_stall         = 1'b1;
        mem_we           = 1'b0;
        mem_waddr        = cur_row_reg;
        mem_wdata        = '0;
        mem_raddr        = last_row_reg;
        do_place         = 1'b0;
        do_emit          = 1'b0;
        emit_status      = ST_NONE;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd_next       = cmd;
                    fsize_next     = frame_size;
                    ts_next        = timestamp_ms;
                    key_next       = is_keyframe;
                    lead_next      = lead_stream;
                    ridx_next      = row_index;
                    cl_flag_next   = 1'b0;
                    cl_row_next    = '0;
                    cl_first_next  = '0;
                    cl_last_next   = '0;
                    cl_repair_next = REP_NONE;
                    cl_fill_next   = '0;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL:
            begin
                case (cmd_reg)
                    CMD_FRAME:
                    begin
                        if (too_big)
                        begin
                            do_emit     = 1'b1;
                            emit_status = ST_DROPPED;
                        end
                        else if (need_close)
                        begin
                            state_next = S_WRCUR;
                        end
                        else
                        begin
                            do_place    = 1'b1;
                            do_emit     = 1'b1;
                            emit_status = ST_PLACED;
                        end
                    end
                    CMD_FLUSH:
                    begin
                        if (fill_reg != '0)
                        begin
                            state_next = S_WRCUR;
                        end
                        else
                        begin
                            do_emit = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        mem_raddr  = row_ok(ridx_reg);
                        state_next = S_ROWRD;
                    end
                    default:
                    begin
                        do_emit = 1'b1;
                    end
                endcase
            end
            S_ROWRD:
            begin
                mem_raddr   = row_ok(ridx_reg);
                do_emit     = 1'b1;
                emit_status = ST_ROW;
            end
            S_WRCUR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = cur_row_reg;
                mem_wdata       = {rep_first, rep_last};
                cl_flag_next    = 1'b1;
                cl_row_next     = ROWF_W'(cur_row_reg);
                cl_first_next   = rep_first;
                cl_last_next    = rep_last;
                cl_repair_next  = rep_code;
                cl_fill_next    = close_fill;
                last_row_next   = cur_row_reg;
                cur_row_next    = row_wrap;
                pend_first_next = '0;
                pend_last_next  = '0;
                fill_next       = '0;
                state_next      = S_WRNEXT;
            end
            S_WRNEXT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_row_reg;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                do_emit = 1'b1;
                if (cmd_reg == CMD_FRAME)
                begin
                    do_place    = 1'b1;
                    emit_status = ST_PLACED;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished item waits in place until the output register frees up.
        if (do_emit && !out_free)
        begin
            do_emit  = 1'b0;
            do_place = 1'b0;
        end
        else if (do_emit)
        begin
            state_next = S_IDLE;
        end

        if (do_place)
        begin
            pend_first_next = pf_new;
            pend_last_next  = pl_new;
            fill_next       = fill_sat;
        end

        if (cfg.start_load)
        begin
            cur_row_next = row_ok(cfg.start_row);
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        o_status_next    = o_status_reg;
        o_offset_next    = o_offset_reg;
        o_next_row_next  = o_next_row_reg;
        o_row_first_next = o_row_first_reg;
        o_row_last_next  = o_row_last_reg;
        if (do_emit)
        begin
            out_valid_next   = 1'b1;
            o_status_next    = emit_status;
            o_offset_next    = do_place ? place_offset : '0;
            o_next_row_next  = ROWF_W'(cur_row_reg);
            o_row_first_next = (emit_status == ST_ROW) ? rd_first : '0;
            o_row_last_next  = (emit_status == ST_ROW) ? rd_last : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            cur_row_reg    <= '0;
            last_row_reg   <= '0;
            fill_reg       <= '0;
            pend_first_reg <= '0;
            pend_last_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cur_row_reg    <= cur_row_next;
            last_row_reg   <= last_row_next;
            fill_reg       <= fill_next;
            pend_first_reg <= pend_first_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Close fields of a closed block stay registered until the
    // output stage needs them; an item that closes nothing cleared them.
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        fsize_reg       <= fsize_next;
        ts_reg          <= ts_next;
        key_reg         <= key_next;
        lead_reg        <= lead_next;
        ridx_reg        <= ridx_next;
        row_base_reg    <= row_base_next;
        cl_flag_reg     <= cl_flag_next;
        cl_row_reg      <= cl_row_next;
        cl_first_reg    <= cl_first_next;
        cl_last_reg     <= cl_last_next;
        cl_repair_reg   <= cl_repair_next;
        cl_fill_reg     <= cl_fill_next;
        o_status_reg    <= o_status_next;
        o_offset_reg    <= o_offset_next;
        o_next_row_reg  <= o_next_row_next;
        o_row_first_reg <= o_row_first_next;
        o_row_last_reg  <= o_row_last_next;
    end

    // The close fields are taken from the item's close registers, which an
    // accepted item clears and a later emit of the same item reads.
    logic                out_cl_flag_reg;
    logic [ROWF_W-1:0]   out_cl_row_reg;
    logic [TS_W-1:0]     out_cl_first_reg;
    logic [TS_W-1:0]     out_cl_last_reg;
    logic [REPAIR_W-1:0] out_cl_repair_reg;
    logic [SIZE_W-1:0]   out_cl_fill_reg;
    logic                out_cl_flag_next;
    logic [ROWF_W-1:0]   out_cl_row_next;
    logic [TS_W-1:0]     out_cl_first_next;
    logic [TS_W-1:0]     out_cl_last_next;
    logic [REPAIR_W-1:0] out_cl_repair_next;
    logic [SIZE_W-1:0]   out_cl_fill_next;

    always_comb
    begin
        out_cl_flag_next   = out_cl_flag_reg;
        out_cl_row_next    = out_cl_row_reg;
        out_cl_first_next  = out_cl_first_reg;
        out_cl_last_next   = out_cl_last_reg;
        out_cl_repair_next = out_cl_repair_reg;
        out_cl_fill_next   = out_cl_fill_reg;
        if (do_emit)
        begin
            out_cl_flag_next   = cl_flag_reg;
            out_cl_row_next    = cl_row_reg;
            out_cl_first_next  = cl_first_reg;
            out_cl_last_next   = cl_last_reg;
            out_cl_repair_next = cl_repair_reg;
            out_cl_fill_next   = cl_fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cl_flag_reg   <= out_cl_flag_next;
        out_cl_row_reg    <= out_cl_row_next;
        out_cl_first_reg  <= out_cl_first_next;
        out_cl_last_reg   <= out_cl_last_next;
        out_cl_repair_reg <= out_cl_repair_next;
        out_cl_fill_reg   <= out_cl_fill_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = o_status_reg;
    assign write_offset    = o_offset_reg;
    assign block_closed    = out_cl_flag_reg;
    assign closed_row      = out_cl_row_reg;
    assign closed_first_ts = out_cl_first_reg;
    assign closed_last_ts  = out_cl_last_reg;
    assign repair_code     = out_cl_repair_reg;
    assign fill_bytes      = out_cl_fill_reg;
    assign next_row        = o_next_row_reg;
    assign row_first_ts    = o_row_first_reg;
    assign row_last_ts     = o_row_last_reg;

endmodule

### rtl/core/recording_block_ring_indexer_top.sv
// A frame that stays in its block is transferred and evaluated; a row read adds
// a table read; a frame or flush that closes a block adds the read of the
// previous row, write of the closed row, clearing of the next row, placement.
// The result sits in an output register, and the next input transfer is taken
// while it waits. After reset the table is cleared one row a cycle, over all
// NUM_ROWS rows, with input stalled; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// Recording block ring indexer
// Places media frames into a ring of storage blocks and keeps, for each closed
// block, the first (keyframe mode) or last keyframe and last-frame timestamps.
// ----------------------------------------------------------------------------
module recording_block_ring_indexer_top #(
    parameter int NUM_ROWS   = rbri_pkg::NUM_ROWS_DEF,
    parameter int MARK_BYTES = rbri_pkg::MARK_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbri_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbri_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rbri_pkg::CMD_W-1:0]        cmd,
    input  logic [rbri_pkg::FRAME_W-1:0]      frame_size,
    input  logic [rbri_pkg::TS_W-1:0]         timestamp_ms,
    input  logic                              is_keyframe,
    input  logic                              lead_stream,
    input  logic [rbri_pkg::ROWF_W-1:0]       row_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rbri_pkg::STATUS_W-1:0]     status,
    output logic [rbri_pkg::OFS_W-1:0]        write_offset,
    output logic                              block_closed,
    output logic [rbri_pkg::ROWF_W-1:0]       closed_row,
    output logic [rbri_pkg::TS_W-1:0]         closed_first_ts,
    output logic [rbri_pkg::TS_W-1:0]         closed_last_ts,
    output logic [rbri_pkg::REPAIR_W-1:0]     repair_code,
    output logic [rbri_pkg::SIZE_W-1:0]       fill_bytes,
    output logic [rbri_pkg::ROWF_W-1:0]       next_row,
    output logic [rbri_pkg::TS_W-1:0]         row_first_ts,
    output logic [rbri_pkg::TS_W-1:0]         row_last_ts
);
    import rbri_pkg::*;

    localparam int ROW_W = $clog2(NUM_ROWS);

    cfg_t               cfg;
    logic               mem_we;
    logic [ROW_W-1:0]   mem_waddr;
    logic [2*TS_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]   mem_raddr;
    logic [2*TS_W-1:0]  mem_rdata;

    rbri_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Both timestamp columns share one table row.
    rbri_ram #(
        .WIDTH (2 * TS_W),
        .DEPTH (NUM_ROWS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rbri_seq #(
        .NUM_ROWS   (NUM_ROWS),
        .MARK_BYTES (MARK_BYTES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .frame_size      (frame_size),
        .timestamp_ms    (timestamp_ms),
        .is_keyframe     (is_keyframe),
        .lead_stream     (lead_stream),
        .row_index       (row_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .write_offset    (write_offset),
        .block_closed    (block_closed),
        .closed_row      (closed_row),
        .closed_first_ts (closed_first_ts),
        .closed_last_ts  (closed_last_ts),
        .repair_code     (repair_code),
        .fill_bytes      (fill_bytes),
        .next_row        (next_row),
        .row_first_ts    (row_first_ts),
        .row_last_ts     (row_last_ts),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

endmodule
